@@ rtl/klx_pkg.sv @@
//------------------------------------------------------------------------------
// klx_pkg
// shared constants and types of the kth largest xor range select block
//------------------------------------------------------------------------------
`default_nettype none
package klx_pkg;
	localparam int MAX_ROWS_D   = 1024;
	localparam int MAX_COLS_D   = 4096;
	localparam int VALUE_BITS_D = 31;
	localparam int NODE_POOL_D  = 131073;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_AP_ROOT,
		ST_AP_RD,
		ST_AP_WR,
		ST_Q_RLO,
		ST_Q_RHI,
		ST_Q_INIT,
		ST_Q_WINIT,
		ST_Q_SRD,
		ST_Q_SHI,
		ST_Q_SHC,
		ST_Q_SLO,
		ST_Q_SLC,
		ST_Q_SACC,
		ST_Q_DEC,
		ST_Q_MRD,
		ST_Q_MHI,
		ST_Q_MHC,
		ST_Q_MLC,
		ST_DONE
	} klx_state_t;
endpackage
`default_nettype wire

@@ rtl/klx_trie_mem.sv @@
//------------------------------------------------------------------------------
// klx_trie_mem
// node store: children pair and pass count, one read and one write port
//------------------------------------------------------------------------------
`default_nettype none
module klx_trie_mem #(
	parameter int NODE_POOL = klx_pkg::NODE_POOL_D,
	parameter int NW = $clog2(NODE_POOL),
	parameter int CW = $clog2(klx_pkg::MAX_COLS_D + 1)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [NW-1:0] waddr,
	input  wire logic [NW-1:0] wc0,
	input  wire logic [NW-1:0] wc1,
	input  wire logic [CW-1:0] wcnt,
	input  wire logic [NW-1:0] raddr,
	output logic      [NW-1:0] rc0,
	output logic      [NW-1:0] rc1,
	output logic      [CW-1:0] rcnt
);
	logic [2*NW+CW-1:0] mem [NODE_POOL];
	logic [2*NW+CW-1:0] rd_q;
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= {wc0, wc1, wcnt};
		rd_q <= mem[raddr];
	end
	assign {rc0, rc1, rcnt} = rd_q;
endmodule
`default_nettype wire

@@ rtl/klx_side_mem.sv @@
//------------------------------------------------------------------------------
// klx_side_mem
// generic one write one read synchronous memory
//------------------------------------------------------------------------------
`default_nettype none
module klx_side_mem #(
	parameter int DEPTH = 1024,
	parameter int AW = $clog2(DEPTH),
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/kth_largest_xor_range_select.sv @@
//------------------------------------------------------------------------------
// kth_largest_xor_range_select
// persistent binary trie, rank-th largest xor over a row and version range
//------------------------------------------------------------------------------
// channel  | signals                                   | rule
// command  | start busy action .. rank                 | start && !busy
// result   | done xor_value                            | one cycle strobe
// load and unknown actions: taken in the idle cycle, busy stays low.
// append: one node read and one node write per level; straight back to idle
//   from the root state when the version table or node pool is full.
// query over R rows: the count pass visits each row in the states SRD, SHI,
//   SHC, SLO, SLC and SACC, the move pass in MRD, MHI, MHC and MLC, all
//   through the single node read port; an empty row range only steps the bits.
// reset clears the state, nodes_used and versions_used; node zero and version
//   zero are never written and read as empty through an address compare.
// results cannot be stalled; busy is high until the result strobe.
`default_nettype none
module kth_largest_xor_range_select #(
	parameter int MAX_ROWS   = klx_pkg::MAX_ROWS_D,
	parameter int MAX_COLS   = klx_pkg::MAX_COLS_D,
	parameter int VALUE_BITS = klx_pkg::VALUE_BITS_D,
	parameter int NODE_POOL  = klx_pkg::NODE_POOL_D
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [9:0]  row_index,
	input  wire logic [30:0] item_value,
	input  wire logic [9:0]  row_first,
	input  wire logic [9:0]  row_last,
	input  wire logic [12:0] col_first,
	input  wire logic [12:0] col_last,
	input  wire logic [22:0] rank,
	output logic             done,
	output logic [30:0]      xor_value
);
	localparam int NW = $clog2(NODE_POOL);
	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int VW = $clog2(MAX_COLS + 1);
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int BW = $clog2(31);
	localparam int SW = 30;
	localparam logic [30:0] VMASK    = 31'((64'd1 << VALUE_BITS) - 64'd1);
	localparam logic [31:0] POOL_TOP = 32'(NODE_POOL - 1);
	localparam logic [31:0] PATH_LEN = 32'(VALUE_BITS + 1);
	localparam logic [31:0] ROW_TOP  = 32'(MAX_ROWS - 1);

	klx_pkg::klx_state_t st_q, st_d;

	logic [30:0]   val_q, rv_q, ans_q;
	logic [RW-1:0] rf_q, rl_q, r_q;
	logic [12:0]   cf_q, cl_q;
	logic          empty_q, leaf_q, take_q;
	logic signed [SW-1:0] rem_q, sum_q;
	logic [BW-1:0] b_q;
	logic [NW-1:0] used_q, old_q, cur_q, lo_q, hi_q;
	logic [VW-1:0] vers_q;

	// trie memory ports
	logic          t_we;
	logic [NW-1:0] t_wa, t_w0, t_w1, t_ra, t_r0, t_r1;
	logic [CW-1:0] t_wc, t_rc;
	logic          t_z_s1;
	logic [NW-1:0] c0, c1;
	logic [CW-1:0] cn;

	klx_trie_mem #(.NODE_POOL(NODE_POOL), .NW(NW), .CW(CW)) u_trie (
		.clk(clk), .we(t_we), .waddr(t_wa), .wc0(t_w0), .wc1(t_w1), .wcnt(t_wc),
		.raddr(t_ra), .rc0(t_r0), .rc1(t_r1), .rcnt(t_rc)
	);
	assign c0 = t_z_s1 ? '0 : t_r0;
	assign c1 = t_z_s1 ? '0 : t_r1;
	assign cn = t_z_s1 ? '0 : t_rc;

	logic          v_we;
	logic [VW-1:0] v_wa, v_ra;
	logic [NW-1:0] v_wd, v_rd, v_root;
	logic          v_z_s1;
	klx_side_mem #(.DEPTH(MAX_COLS + 1), .AW(VW), .DW(NW)) u_roots (
		.clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd)
	);
	assign v_root = v_z_s1 ? '0 : v_rd;

	logic          r_we;
	logic [30:0]   r_wd, r_rd;
	assign r_wd = item_value & VMASK;
	klx_side_mem #(.DEPTH(MAX_ROWS), .AW(RW), .DW(31)) u_rows (
		.clk(clk), .we(r_we), .waddr(row_index[RW-1:0]), .wdata(r_wd), .raddr(r_q),
		.rdata(r_rd)
	);

	logic            w_we;
	logic [2*NW-1:0] w_wd, w_rd;
	klx_side_mem #(.DEPTH(MAX_ROWS), .AW(RW), .DW(2*NW)) u_walk (
		.clk(clk), .we(w_we), .waddr(r_q), .wdata(w_wd), .raddr(r_q), .rdata(w_rd)
	);

	logic [31:0]   cfm, vers_w, rl_lim;
	logic [VW-1:0] vlo, vhi;
	logic          dir, want, mdir, row_end, bit_last, cap_full;
	logic [NW-1:0] nxt;
	assign cfm = (cf_q == 13'd0) ? 32'd0 : {19'd0, cf_q} - 32'd1;
	assign vers_w = 32'(vers_q);
	assign vlo = (cfm > vers_w) ? vers_q : VW'(cfm);
	assign vhi = ({19'd0, cl_q} > vers_w) ? vers_q : VW'(cl_q);
	assign rl_lim = ({22'd0, row_last} > ROW_TOP) ? ROW_TOP : {22'd0, row_last};
	assign dir = val_q[b_q];
	assign want = ~rv_q[b_q];
	assign mdir = rv_q[b_q] ^ take_q;
	assign row_end = (r_q == rl_q);
	assign bit_last = (b_q == '0);
	assign cap_full = (vers_w >= 32'(MAX_COLS)) || (32'(used_q) + PATH_LEN > POOL_TOP);
	assign nxt = NW'(cur_q + 1'b1);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			klx_pkg::ST_IDLE: begin
				if (start) begin
					unique case (action)
						klx_pkg::ACT_APPEND: st_d = klx_pkg::ST_AP_ROOT;
						klx_pkg::ACT_QUERY:  st_d = klx_pkg::ST_Q_RLO;
						default:             st_d = klx_pkg::ST_IDLE;
					endcase
				end
			end
			klx_pkg::ST_AP_ROOT: st_d = cap_full ? klx_pkg::ST_IDLE : klx_pkg::ST_AP_RD;
			klx_pkg::ST_AP_RD: st_d = klx_pkg::ST_AP_WR;
			klx_pkg::ST_AP_WR: st_d = leaf_q ? klx_pkg::ST_IDLE : klx_pkg::ST_AP_RD;
			klx_pkg::ST_Q_RLO: st_d = klx_pkg::ST_Q_RHI;
			klx_pkg::ST_Q_RHI: st_d = klx_pkg::ST_Q_INIT;
			klx_pkg::ST_Q_INIT: st_d = empty_q ? klx_pkg::ST_Q_DEC : klx_pkg::ST_Q_WINIT;
			klx_pkg::ST_Q_WINIT: st_d = row_end ? klx_pkg::ST_Q_SRD : klx_pkg::ST_Q_WINIT;
			klx_pkg::ST_Q_SRD: st_d = klx_pkg::ST_Q_SHI;
			klx_pkg::ST_Q_SHI: st_d = klx_pkg::ST_Q_SHC;
			klx_pkg::ST_Q_SHC: st_d = klx_pkg::ST_Q_SLO;
			klx_pkg::ST_Q_SLO: st_d = klx_pkg::ST_Q_SLC;
			klx_pkg::ST_Q_SLC: st_d = klx_pkg::ST_Q_SACC;
			klx_pkg::ST_Q_SACC: st_d = row_end ? klx_pkg::ST_Q_DEC : klx_pkg::ST_Q_SRD;
			klx_pkg::ST_Q_DEC: begin
				if (!empty_q)
					st_d = klx_pkg::ST_Q_MRD;
				else if (bit_last)
					st_d = klx_pkg::ST_DONE;
				else
					st_d = klx_pkg::ST_Q_DEC;
			end
			klx_pkg::ST_Q_MRD: st_d = klx_pkg::ST_Q_MHI;
			klx_pkg::ST_Q_MHI: st_d = klx_pkg::ST_Q_MHC;
			klx_pkg::ST_Q_MHC: st_d = klx_pkg::ST_Q_MLC;
			klx_pkg::ST_Q_MLC: begin
				if (!row_end)
					st_d = klx_pkg::ST_Q_MRD;
				else if (bit_last)
					st_d = klx_pkg::ST_DONE;
				else
					st_d = klx_pkg::ST_Q_SRD;
			end
			klx_pkg::ST_DONE: st_d = klx_pkg::ST_IDLE;
			default: st_d = klx_pkg::ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		t_we = 1'b0;
		t_wa = cur_q;
		t_w0 = c0;
		t_w1 = c1;
		t_wc = CW'(cn + 1'b1);
		t_ra = old_q;
		v_we = 1'b0;
		v_wa = VW'(vers_q + 1'b1);
		v_wd = NW'(used_q + 1'b1);
		v_ra = vers_q;
		r_we = 1'b0;
		w_we = 1'b0;
		w_wd = {lo_q, hi_q};
		unique case (st_q)
			klx_pkg::ST_IDLE: begin
				r_we = start && (action == klx_pkg::ACT_LOAD) &&
				       ({22'd0, row_index} < 32'(MAX_ROWS));
			end
			klx_pkg::ST_AP_WR: begin
				t_we = 1'b1;
				if (!leaf_q) begin
					if (dir) t_w1 = nxt;
					else     t_w0 = nxt;
				end
				v_we = leaf_q;
			end
			klx_pkg::ST_Q_RLO: v_ra = vlo;
			klx_pkg::ST_Q_RHI: v_ra = vhi;
			klx_pkg::ST_Q_WINIT: w_we = 1'b1;
			klx_pkg::ST_Q_SHI, klx_pkg::ST_Q_MHI: t_ra = w_rd[NW-1:0];
			klx_pkg::ST_Q_SHC, klx_pkg::ST_Q_SLC: t_ra = want ? c1 : c0;
			klx_pkg::ST_Q_SLO, klx_pkg::ST_Q_MHC: t_ra = lo_q;
			klx_pkg::ST_Q_MLC: begin
				w_we = 1'b1;
				w_wd = {mdir ? c1 : c0, hi_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= klx_pkg::ST_IDLE;
			used_q <= '0;
			vers_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == klx_pkg::ST_AP_WR && leaf_q) begin
				used_q <= NW'(32'(used_q) + PATH_LEN);
				vers_q <= VW'(vers_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		t_z_s1 <= (t_ra == '0);
		v_z_s1 <= (v_ra == '0);
		case (st_q)
			klx_pkg::ST_IDLE: begin
				val_q <= item_value & VMASK;
				rf_q <= RW'(row_first);
				rl_q <= RW'(rl_lim);
				empty_q <= ({22'd0, row_first} > rl_lim);
				cf_q <= col_first;
				cl_q <= col_last;
				rem_q <= $signed({{(SW-23){1'b0}}, rank});
				ans_q <= '0;
				b_q <= BW'(VALUE_BITS - 1);
				leaf_q <= 1'b0;
			end
			klx_pkg::ST_AP_ROOT: begin
				old_q <= v_root;
				cur_q <= NW'(used_q + 1'b1);
			end
			klx_pkg::ST_AP_WR: begin
				old_q <= dir ? c1 : c0;
				cur_q <= nxt;
				if (bit_last) leaf_q <= 1'b1;
				else b_q <= BW'(b_q - 1'b1);
			end
			klx_pkg::ST_Q_RHI: lo_q <= v_root;
			klx_pkg::ST_Q_INIT: begin
				hi_q <= v_root;
				r_q <= rf_q;
				sum_q <= '0;
			end
			klx_pkg::ST_Q_WINIT: r_q <= row_end ? rf_q : RW'(r_q + 1'b1);
			klx_pkg::ST_Q_SHI, klx_pkg::ST_Q_MHI: begin
				rv_q <= r_rd;
				lo_q <= w_rd[2*NW-1:NW];
				hi_q <= w_rd[NW-1:0];
			end
			klx_pkg::ST_Q_SLO: sum_q <= sum_q + $signed({{(SW-CW){1'b0}}, cn});
			klx_pkg::ST_Q_SACC: begin
				sum_q <= sum_q - $signed({{(SW-CW){1'b0}}, cn});
				r_q <= row_end ? rf_q : RW'(r_q + 1'b1);
			end
			klx_pkg::ST_Q_DEC: begin
				take_q <= (sum_q >= rem_q);
				if (sum_q >= rem_q) ans_q[b_q] <= 1'b1;
				else rem_q <= rem_q - sum_q;
				sum_q <= '0;
				if (empty_q && !bit_last) b_q <= BW'(b_q - 1'b1);
			end
			klx_pkg::ST_Q_MHC: hi_q <= mdir ? c1 : c0;
			klx_pkg::ST_Q_MLC: begin
				r_q <= row_end ? rf_q : RW'(r_q + 1'b1);
				if (row_end && !bit_last) b_q <= BW'(b_q - 1'b1);
			end
			default: ;
		endcase
	end

	assign busy = (st_q != klx_pkg::ST_IDLE);
	assign done = (st_q == klx_pkg::ST_DONE);
	assign xor_value = ans_q;
endmodule
`default_nettype wire
